// File: rtl/core/ptsch_pkg.sv
// Shared constants, types and helper functions of the periodic timer scheduler.
package ptsch_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int MAX_FIRE   = 16;
   localparam int FIRE_IDX_W = $clog2(MAX_FIRE);
   localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

   localparam int HANDLE_W = 4;
   localparam int STATUS_W = 3;
   localparam int REQ_W    = 2;
   localparam int TPM_W    = 23;
   localparam int DELAY_W  = 32;
   localparam int OFFSET_W = TPM_W + DELAY_W;
   localparam int COUNT_W  = 64;

   localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(19200);

   localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ONE_SHOT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PERIODIC = 2'd2;
   localparam logic [REQ_W-1:0] REQ_DESCHED  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FIRED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_DELAY = 3'd4;

   typedef struct packed {
      logic start;
      logic fire_mode;
   } scan_cmd_type;

   typedef struct packed {
      logic               done;
      logic               found;
      logic [IDX_W-1:0]   pick;
      logic [COUNT_W-1:0] best;
   } scan_res_type;

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

   function automatic logic [HANDLE_W-1:0] to_handle(input logic [IDX_W-1:0] idx);
      logic [IDX_W+HANDLE_W-1:0] ext;
      ext = (IDX_W + HANDLE_W)'(idx);
      return ext[HANDLE_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] from_handle(input logic [HANDLE_W-1:0] h);
      logic [IDX_W+HANDLE_W-1:0] ext;
      ext = (IDX_W + HANDLE_W)'(h);
      return ext[IDX_W-1:0];
   endfunction

   function automatic logic handle_in_range(input logic [HANDLE_W-1:0] h);
      return (CNT_W + HANDLE_W)'(h) < (CNT_W + HANDLE_W)'(NUM_SLOTS);
   endfunction

endpackage

// File: rtl/core/ptsch_slot_ram.sv
// Per-slot 64-bit storage with one write port and one registered read port.
module ptsch_slot_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ptsch_pkg::IDX_W-1:0]  wr_addr,
   input  logic [ptsch_pkg::COUNT_W-1:0] wr_data,
   input  logic [ptsch_pkg::IDX_W-1:0]  rd_addr,
   output logic [ptsch_pkg::COUNT_W-1:0] rd_data
);
   import ptsch_pkg::*;

   logic [COUNT_W-1:0] mem [NUM_SLOTS];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ptsch_min_scan.sv
// Shared compare unit that walks all slots and keeps the earliest qualifying due count.
module ptsch_min_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  ptsch_pkg::scan_cmd_type        cmd,
   input  logic [ptsch_pkg::COUNT_W-1:0]  tick_count,
   input  logic [ptsch_pkg::NUM_SLOTS-1:0] slot_valid,
   input  logic [ptsch_pkg::NUM_SLOTS-1:0] slot_fired,
   output logic [ptsch_pkg::IDX_W-1:0]    rd_addr,
   input  logic [ptsch_pkg::COUNT_W-1:0]  rd_data,
   output ptsch_pkg::scan_res_type        res
);
   import ptsch_pkg::*;

   logic               running_ff, running_in;
   logic               fire_mode_ff, fire_mode_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic               done_ff, done_in;
   logic               issue;
   logic               cand;

   assign issue   = running_ff && (addr_ff < CNT_W'(NUM_SLOTS));
   assign rd_addr = addr_ff[IDX_W-1:0];

   // In fire mode a slot must be due and not yet fired on this tick.
   assign cand = chk_valid_ff && slot_valid[chk_idx_ff]
                 && (!fire_mode_ff || (!slot_fired[chk_idx_ff] && (rd_data <= tick_count)))
                 && (!found_ff || (rd_data < best_ff));

   always_comb begin
      running_in   = running_ff;
      fire_mode_in = fire_mode_ff;
      addr_in      = addr_ff;
      chk_valid_in = issue;
      chk_idx_in   = addr_ff[IDX_W-1:0];
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      done_in      = 1'b0;
      if (cmd.start) begin
         running_in   = 1'b1;
         fire_mode_in = cmd.fire_mode;
         addr_in      = '0;
         chk_valid_in = 1'b0;
         found_in     = 1'b0;
      end else begin
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         if (cand) begin
            found_in = 1'b1;
            pick_in  = chk_idx_ff;
            best_in  = rd_data;
         end
         if (running_ff && !issue && chk_valid_ff) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         chk_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         found_ff     <= 1'b0;
         addr_ff      <= '0;
      end else begin
         running_ff   <= running_in;
         chk_valid_ff <= chk_valid_in;
         done_ff      <= done_in;
         found_ff     <= found_in;
         addr_ff      <= addr_in;
      end
      fire_mode_ff <= fire_mode_in;
      chk_idx_ff   <= chk_idx_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
   end

   always_comb begin
      res.done  = done_ff;
      res.found = found_ff;
      res.pick  = pick_ff;
      res.best  = best_ff;
   end

endmodule

// File: rtl/core/periodic_timer_scheduler.sv
// Top level of the periodic timer scheduler: request sequencer, slot state and result output.
//
// Multi-slot timer engine with a 64-bit tick counter. One request is handled at a time and
// req_stall stays high until its last response has been taken. Every request but a tick with
// nothing due ends with one pass of the shared compare unit over all slots to find the next
// compare value. A deschedule or rejected schedule goes straight to that pass, an accepted
// schedule first writes its slot. A tick runs one fire pass per fired slot, each followed by
// its slot update, and then one fire pass with nothing due unless MAX_FIRE slots have fired;
// the final pass follows, then the responses at one per cycle while rsp_stall is low. A tick
// with nothing due gives no response.
// All responses of one request carry armed and next_due as they stand after the whole request.
module periodic_timer_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ptsch_pkg::TPM_W-1:0]     csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptsch_pkg::REQ_W-1:0]     req_type,
   input  logic [ptsch_pkg::DELAY_W-1:0]   req_delay,
   input  logic [ptsch_pkg::HANDLE_W-1:0]  req_slot_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ptsch_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ptsch_pkg::HANDLE_W-1:0]  rsp_handle,
   output logic                            rsp_armed,
   output logic [ptsch_pkg::COUNT_W-1:0]   rsp_next_due,
   output logic                            rsp_last
);
   import ptsch_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCHED_WR,
      S_FIRE_SCAN,
      S_FIRE_UPD,
      S_FIN_SCAN,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [TPM_W-1:0]      tpm_ff, tpm_in;
   logic [COUNT_W-1:0]    tick_ff, tick_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]  fired_ff, fired_in;
   logic [FIRE_CNT_W-1:0] nres_ff, nres_in;
   logic [FIRE_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [HANDLE_W-1:0]   hbuf_ff [MAX_FIRE];
   logic [HANDLE_W-1:0]   hbuf_in [MAX_FIRE];
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic                  periodic_ff, periodic_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic                  armed_ff, armed_in;
   logic [COUNT_W-1:0]    next_due_ff, next_due_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [TPM_W-1:0]      tpm_eff;
   logic [IDX_W-1:0]      sh_idx;
   logic                  is_last;

   scan_cmd_type          scan_cmd;
   scan_res_type          scan_res;
   logic [IDX_W-1:0]      due_rd_addr;
   logic [COUNT_W-1:0]    due_rd_data;
   logic [COUNT_W-1:0]    per_rd_data;
   logic                  due_wr_en;
   logic                  per_wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [COUNT_W-1:0]    due_wr_data;
   logic [COUNT_W-1:0]    per_wr_data;

   ptsch_slot_ram u_due_ram (
      .clock   (clock),
      .wr_en   (due_wr_en),
      .wr_addr (wr_addr),
      .wr_data (due_wr_data),
      .rd_addr (due_rd_addr),
      .rd_data (due_rd_data)
   );

   // The period is read at the slot the last scan picked.
   ptsch_slot_ram u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (wr_addr),
      .wr_data (per_wr_data),
      .rd_addr (scan_res.pick),
      .rd_data (per_rd_data)
   );

   ptsch_min_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cmd        (scan_cmd),
      .tick_count (tick_ff),
      .slot_valid (valid_ff),
      .slot_fired (fired_ff),
      .rd_addr    (due_rd_addr),
      .rd_data    (due_rd_data),
      .res        (scan_res)
   );

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign tpm_eff   = (tpm_ff == '0) ? TPM_W'(1) : tpm_ff;
   assign sh_idx    = from_handle(req_slot_handle);
   assign is_last   = (FIRE_CNT_W'(emit_idx_ff) + FIRE_CNT_W'(1)) == nres_ff;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      tpm_in       = csr_wr_en ? csr_wr_data : tpm_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      fired_in     = fired_ff;
      nres_in      = nres_ff;
      emit_idx_in  = emit_idx_ff;
      hbuf_in      = hbuf_ff;
      status_in    = status_ff;
      free_in      = free_ff;
      periodic_in  = periodic_ff;
      offset_in    = offset_ff;
      armed_in     = armed_ff;
      next_due_in  = next_due_ff;
      rsp_valid_in = rsp_valid_ff;
      scan_cmd     = '0;
      due_wr_en    = 1'b0;
      per_wr_en    = 1'b0;
      wr_addr      = free_ff;
      due_wr_data  = sat_add(tick_ff, COUNT_W'(offset_ff));
      per_wr_data  = periodic_ff ? COUNT_W'(offset_ff) : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               nres_in = FIRE_CNT_W'(1);
               unique case (req_type)
                  REQ_TICK: begin
                     tick_in            = tick_ff + COUNT_W'(1);
                     fired_in           = '0;
                     nres_in            = '0;
                     status_in          = ST_FIRED;
                     scan_cmd.start     = 1'b1;
                     scan_cmd.fire_mode = 1'b1;
                     state_in           = S_FIRE_SCAN;
                  end
                  REQ_ONE_SHOT, REQ_PERIODIC: begin
                     hbuf_in[0] = '0;
                     if (req_delay == '0) begin
                        status_in      = ST_ZERO_DELAY;
                        scan_cmd.start = 1'b1;
                        state_in       = S_FIN_SCAN;
                     end else if (!free_found) begin
                        status_in      = ST_NO_SLOT;
                        scan_cmd.start = 1'b1;
                        state_in       = S_FIN_SCAN;
                     end else begin
                        status_in   = ST_OK;
                        hbuf_in[0]  = to_handle(free_idx);
                        free_in     = free_idx;
                        periodic_in = (req_type == REQ_PERIODIC);
                        offset_in   = OFFSET_W'(tpm_eff) * OFFSET_W'(req_delay);
                        state_in    = S_SCHED_WR;
                     end
                  end
                  REQ_DESCHED: begin
                     hbuf_in[0] = req_slot_handle;
                     if (handle_in_range(req_slot_handle) && valid_ff[sh_idx]) begin
                        valid_in[sh_idx] = 1'b0;
                        status_in        = ST_OK;
                     end else begin
                        status_in = ST_BAD_HANDLE;
                     end
                     scan_cmd.start = 1'b1;
                     state_in       = S_FIN_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCHED_WR: begin
            due_wr_en         = 1'b1;
            per_wr_en         = 1'b1;
            valid_in[free_ff] = 1'b1;
            scan_cmd.start    = 1'b1;
            state_in          = S_FIN_SCAN;
         end
         S_FIRE_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  state_in = S_FIRE_UPD;
               end else if (nres_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  scan_cmd.start = 1'b1;
                  state_in       = S_FIN_SCAN;
               end
            end
         end
         S_FIRE_UPD: begin
            // Periodic slots move on by their period; one-shot slots are released.
            wr_addr                           = scan_res.pick;
            due_wr_data                       = sat_add(scan_res.best, per_rd_data);
            fired_in[scan_res.pick]           = 1'b1;
            hbuf_in[nres_ff[FIRE_IDX_W-1:0]]  = to_handle(scan_res.pick);
            nres_in                           = nres_ff + FIRE_CNT_W'(1);
            if (per_rd_data == '0) begin
               valid_in[scan_res.pick] = 1'b0;
            end else begin
               due_wr_en = 1'b1;
            end
            scan_cmd.start = 1'b1;
            if (nres_ff == FIRE_CNT_W'(MAX_FIRE - 1)) begin
               state_in = S_FIN_SCAN;
            end else begin
               scan_cmd.fire_mode = 1'b1;
               state_in           = S_FIRE_SCAN;
            end
         end
         S_FIN_SCAN: begin
            if (scan_res.done) begin
               armed_in     = scan_res.found;
               next_due_in  = scan_res.found ? scan_res.best : '0;
               emit_idx_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (is_last) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + FIRE_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpm_ff       <= TPM_RESET;
         tick_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         nres_ff      <= '0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         tpm_ff       <= tpm_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         nres_ff      <= nres_in;
         emit_idx_ff  <= emit_idx_in;
      end
      fired_ff    <= fired_in;
      hbuf_ff     <= hbuf_in;
      status_ff   <= status_in;
      free_ff     <= free_in;
      periodic_ff <= periodic_in;
      offset_ff   <= offset_in;
      armed_ff    <= armed_in;
      next_due_ff <= next_due_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_handle   = hbuf_ff[emit_idx_ff];
   assign rsp_armed    = armed_ff;
   assign rsp_next_due = next_due_ff;
   assign rsp_last     = is_last;

endmodule

// File: test/ptsch_scoreboard_pkg.sv
// Response predictor and scoreboard for the periodic timer scheduler testbench.
package ptsch_scoreboard_pkg;

   import ptsch_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic                armed;
      logic [COUNT_W-1:0]  next_due;
      logic                last;
   } timer_response_type;

   class timer_scoreboard;
      logic [TPM_W-1:0]   rate;
      logic [COUNT_W-1:0] tick_now;
      bit                 slot_on[NUM_SLOTS];
      logic [COUNT_W-1:0] due_at[NUM_SLOTS];
      logic [COUNT_W-1:0] reload[NUM_SLOTS];
      timer_response_type expected_q[$];
      int                 mismatches;
      int                 requests_seen;
      int                 responses_seen;
      int                 expirations;

      function new();
         rate = TPM_RESET;
         tick_now = '0;
         foreach (slot_on[i]) begin
            slot_on[i] = 1'b0;
            due_at[i] = '0;
            reload[i] = '0;
         end
         mismatches = 0;
         requests_seen = 0;
         responses_seen = 0;
         expirations = 0;
      endfunction

      function void set_rate(logic [TPM_W-1:0] value);
         rate = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [COUNT_W-1:0] clamp_sum(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
         logic [COUNT_W:0] wide;
         wide = {1'b0, a} + {1'b0, b};
         return wide[COUNT_W] ? {COUNT_W{1'b1}} : wide[COUNT_W-1:0];
      endfunction

      // Works out every response that one accepted request causes.
      function void note_request(logic [REQ_W-1:0] kind, logic [DELAY_W-1:0] delay,
                                 logic [HANDLE_W-1:0] slot);
         timer_response_type batch[$];
         timer_response_type one;
         bit                 fired[NUM_SLOTS];
         int                 pick;
         int                 free_idx;
         logic [COUNT_W-1:0] offset;
         logic [TPM_W-1:0]   step_rate;
         logic               any_on;
         logic [COUNT_W-1:0] least;

         requests_seen++;
         one.armed = 1'b0;
         one.next_due = '0;
         one.last = 1'b0;
         foreach (fired[i]) fired[i] = 1'b0;
         case (kind)
            REQ_TICK: begin
               tick_now = tick_now + COUNT_W'(1);
               do begin
                  pick = -1;
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (slot_on[i] && !fired[i] && due_at[i] <= tick_now &&
                         (pick < 0 || due_at[i] < due_at[pick]))
                        pick = i;
                  end
                  if (pick >= 0) begin
                     fired[pick] = 1'b1;
                     if (reload[pick] == '0)
                        slot_on[pick] = 1'b0;
                     else
                        due_at[pick] = clamp_sum(due_at[pick], reload[pick]);
                     one.status = ST_FIRED;
                     one.handle = HANDLE_W'(pick);
                     batch.push_back(one);
                     expirations++;
                  end
               end while (pick >= 0 && batch.size() < MAX_FIRE);
            end
            REQ_ONE_SHOT, REQ_PERIODIC: begin
               one.handle = '0;
               if (delay == '0) begin
                  one.status = ST_ZERO_DELAY;
               end else begin
                  free_idx = -1;
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (!slot_on[i] && free_idx < 0)
                        free_idx = i;
                  end
                  if (free_idx < 0) begin
                     one.status = ST_NO_SLOT;
                  end else begin
                     // A rate of zero counts as one tick per millisecond.
                     step_rate = (rate == '0) ? TPM_W'(1) : rate;
                     offset = COUNT_W'(step_rate) * COUNT_W'(delay);
                     slot_on[free_idx] = 1'b1;
                     due_at[free_idx] = clamp_sum(tick_now, offset);
                     reload[free_idx] = (kind == REQ_PERIODIC) ? offset : '0;
                     one.status = ST_OK;
                     one.handle = HANDLE_W'(free_idx);
                  end
               end
               batch.push_back(one);
            end
            default: begin
               one.handle = slot;
               if (slot_on[slot]) begin
                  slot_on[slot] = 1'b0;
                  one.status = ST_OK;
               end else begin
                  one.status = ST_BAD_HANDLE;
               end
               batch.push_back(one);
            end
         endcase

         // Every response of the request reports the state after the whole request.
         any_on = 1'b0;
         least = '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_on[i] && (!any_on || due_at[i] < least)) begin
               least = due_at[i];
               any_on = 1'b1;
            end
         end
         foreach (batch[k]) begin
            batch[k].armed = any_on;
            batch[k].next_due = any_on ? least : '0;
            batch[k].last = (k == batch.size() - 1);
            expected_q.push_back(batch[k]);
         end
      endfunction

      function void compare_field(string name, logic [COUNT_W-1:0] want,
                                  logic [COUNT_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(timer_response_type got);
         timer_response_type want;
         responses_seen++;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: status %0d handle %0d",
                   got.status, got.handle);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
         compare_field("handle", COUNT_W'(want.handle), COUNT_W'(got.handle));
         compare_field("armed", COUNT_W'(want.armed), COUNT_W'(got.armed));
         compare_field("next_due", want.next_due, got.next_due);
         compare_field("last", COUNT_W'(want.last), COUNT_W'(got.last));
      endfunction
   endclass

endpackage

// File: test/testbench.sv
// Top-level testbench of the periodic timer scheduler with stimulus, stalls and watchdog.
module testbench;

   import ptsch_pkg::*;
   import ptsch_scoreboard_pkg::*;

   localparam int SETTLE_CYCLES   = 4 * (NUM_SLOTS + 3);
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [TPM_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type = REQ_TICK;
   logic [DELAY_W-1:0]  req_delay = '0;
   logic [HANDLE_W-1:0] req_slot_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_handle;
   logic                rsp_armed;
   logic [COUNT_W-1:0]  rsp_next_due;
   logic                rsp_last;

   bit              steady = 1'b0;
   bit              hold_off_pending = 1'b0;
   int              quiet_cycles = 0;
   timer_scoreboard sb;

   periodic_timer_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_delay       (req_delay),
      .req_slot_handle (req_slot_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_handle      (rsp_handle),
      .rsp_armed       (rsp_armed),
      .rsp_next_due    (rsp_next_due),
      .rsp_last        (rsp_last)
   );

   always #4 clock = ~clock;

   // The valid stays high after an accept; the next call either idles it or reuses it.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DELAY_W-1:0] delay,
                               input logic [HANDLE_W-1:0] slot);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_delay <= delay;
      req_slot_handle <= slot;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, delay, slot);
   endtask

   // Waits until the block is idle: all responses in, and any silent tick finished.
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [TPM_W-1:0] value);
      drain_requests();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_rate(value);
   endtask

   task automatic run_random(input int count);
      logic [REQ_W-1:0]    kind;
      logic [DELAY_W-1:0]  delay;
      logic [HANDLE_W-1:0] slot;
      int                  roll;
      int                  live[$];
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         kind = (roll < 50) ? REQ_TICK : (roll < 68) ? REQ_ONE_SHOT :
                (roll < 85) ? REQ_PERIODIC : REQ_DESCHED;
         roll = $urandom_range(99);
         delay = (roll < 5) ? '0 : (roll < 15) ? DELAY_W'($urandom()) :
                 DELAY_W'($urandom_range(12, 1));
         slot = HANDLE_W'($urandom_range(NUM_SLOTS - 1));
         // Most removals target a live timer so that slots keep turning over.
         live.delete();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sb.slot_on[i])
               live.push_back(i);
         end
         if (kind == REQ_DESCHED && live.size() > 0 && $urandom_range(3) != 0)
            slot = HANDLE_W'(live[$urandom_range(live.size() - 1)]);
         send_request(kind, delay, slot);
      end
   endtask

   always begin
      @(posedge clock);
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         repeat (HOLD_OFF_CYCLES) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
      end
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      timer_response_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.handle = rsp_handle;
         got.armed = rsp_armed;
         got.next_due = rsp_next_due;
         got.last = rsp_last;
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // At the reset rate: silent tick, a bad handle, zero delays, longest delay and its removal.
      send_request(REQ_TICK, '0, '0);
      send_request(REQ_DESCHED, '0, 4'hF);
      send_request(REQ_ONE_SHOT, '0, '0);
      send_request(REQ_PERIODIC, '0, 4'hA);
      send_request(REQ_PERIODIC, 32'hFFFF_FFFF, '0);
      send_request(REQ_DESCHED, 32'hFFFF_FFFF, '0);

      // Fill every slot with the same due count, overflow the table, then fire all at once.
      write_rate(TPM_W'(1));
      for (int i = 0; i < NUM_SLOTS; i++)
         send_request((i % 2 == 0) ? REQ_PERIODIC : REQ_ONE_SHOT, DELAY_W'(2), '0);
      send_request(REQ_ONE_SHOT, DELAY_W'(5), '0);
      repeat (4) send_request(REQ_TICK, '0, '0);

      run_random(90);

      write_rate('0);
      steady = 1'b1;
      run_random(50);
      steady = 1'b0;

      write_rate(TPM_W'(3));
      hold_off_pending = 1'b1;
      run_random(60);

      write_rate(TPM_W'(4294967));
      run_random(25);

      write_rate({TPM_W{1'b1}});
      run_random(25);

      write_rate(TPM_W'(2));
      run_random(33);

      drain_requests();
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.mismatches++;
      end
      $display("Covered %0d requests and %0d checked responses, %0d of them timer expirations,",
               sb.requests_seen, sb.responses_seen, sb.expirations);
      $display("across seven tick rates including zero and the field maximum.");
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: periodic_timer_scheduler.f
rtl/core/ptsch_pkg.sv
rtl/core/ptsch_slot_ram.sv
rtl/core/ptsch_min_scan.sv
rtl/core/periodic_timer_scheduler.sv
test/ptsch_scoreboard_pkg.sv
test/testbench.sv
